@@ rtl/assert_macros.svh @@
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property checked on every rising edge outside reset
`define LPD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// same, with a message of the caller's choosing
`define LPD_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

`else

`define LPD_ASSERT(lbl, clk, rst_n, prop)
`define LPD_ASSERT_MSG(lbl, clk, rst_n, prop, msg)

`endif

`endif

@@ rtl/lpd_pkg.sv @@
// shared constants and types of the length-prefixed deframer
package lpd_pkg;

    localparam int BYTE_W       = 8;
    localparam int WORD_W       = 32;
    localparam int HEADER_BYTES = 8;
    localparam int HALF_BYTES   = HEADER_BYTES / 2;
    localparam int TOTAL_EXTRA  = 4;
    localparam int CNT_W        = $clog2(HEADER_BYTES);
    localparam int KIND_W       = 2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd2;

    // error codes
    localparam logic ERR_OVER_LIMIT = 1'b0;
    localparam logic ERR_MISMATCH   = 1'b1;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] payload_byte;
        logic              last_in_frame;
        logic              error_code;
    } t_result;

    typedef struct packed {
        logic halted;
        logic in_payload;
    } t_status;

endpackage

@@ rtl/lpd_if.sv @@
// valid/ready channels for stream bytes and for results
interface lpd_byte_if;
    logic                      valid;
    logic                      ready;
    logic [lpd_pkg::BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface lpd_result_if;
    logic                       valid;
    logic                       ready;
    logic [lpd_pkg::KIND_W-1:0] kind;
    logic [lpd_pkg::BYTE_W-1:0] payload_byte;
    logic                       last_in_frame;
    logic                       error_code;

    modport source (output valid, output kind, output payload_byte,
                    output last_in_frame, output error_code, input ready);
    modport sink   (input valid, input kind, input payload_byte,
                    input last_in_frame, input error_code, output ready);
endinterface

@@ rtl/length_prefixed_deframer.sv @@
// top level of the length-prefixed frame deframer
//
//  channel   dir  handshake      payload
//  i_in      in   valid/ready    in_byte
//  o_out     out  valid/ready    kind, payload_byte, last_in_frame, error_code
//  i_cfg_*   in   write enable   max_payload (32 bits)
//
// one word per cycle while the result register has room; a result is loaded into the
// output register as its word leaves the input register; of header words only the last
// of a bad or empty header gives a result, words after an error none; all are consumed
// synchronous active-low reset clears the limit, header count, payload count, halt
// an unread result stalls the parser, and the input register then fills and drops ready
`include "assert_macros.svh"

module length_prefixed_deframer (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [lpd_pkg::WORD_W-1:0] i_cfg_data,
    lpd_byte_if.sink                   i_in,
    lpd_result_if.source               o_out
);

    logic                       w_adv;
    logic                       w_held_valid;
    logic [lpd_pkg::BYTE_W-1:0] w_held_byte;
    logic                       w_out_free;
    logic                       w_res_valid;
    lpd_pkg::t_result           w_res;
    lpd_pkg::t_status           w_status;

    // held word moves on when the result register has room
    assign w_adv = w_held_valid && w_out_free;

    // input register
    lpd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_adv   (w_adv),
        .o_valid (w_held_valid),
        .o_byte  (w_held_byte)
    );

    // parser
    lpd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_step      (w_adv),
        .i_byte      (w_held_byte),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .o_status    (w_status)
    );

    // result register
    lpd_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_res_valid),
        .i_res   (w_res),
        .o_free  (w_out_free),
        .o_out   (o_out)
    );

    // checks
    `LPD_ASSERT_MSG(a_error_halts, i_clk, i_rst_n, w_res_valid && (w_res.kind == lpd_pkg::KIND_ERROR) |=> w_status.halted, "error result did not halt the parser")
    `LPD_ASSERT_MSG(a_halt_sticks, i_clk, i_rst_n, w_status.halted |=> w_status.halted, "halt cleared without reset")
    `LPD_ASSERT_MSG(a_halt_silent, i_clk, i_rst_n, w_status.halted |-> !w_res_valid, "result produced while halted")
    `LPD_ASSERT(a_halt_no_payload, i_clk, i_rst_n, !(w_status.halted && w_status.in_payload && $past(!w_status.halted)) || $past(w_status.in_payload))

endmodule

@@ rtl/lpd_in_reg.sv @@
// input register: holds one stream word until the parser takes it
module lpd_in_reg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    lpd_byte_if.sink                   i_in,
    input  logic                       i_adv,
    output logic                       o_valid,
    output logic [lpd_pkg::BYTE_W-1:0] o_byte
);

    logic                       r_valid;
    logic [lpd_pkg::BYTE_W-1:0] r_byte;

    // free when empty or when the held word moves on this cycle
    assign i_in.ready = !r_valid || i_adv;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    // word capture
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_byte <= i_in.in_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

@@ rtl/lpd_parser.sv @@
// header gathering, checks and payload counting, one word per step
module lpd_parser (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [lpd_pkg::WORD_W-1:0] i_cfg_data,
    input  logic                       i_step,
    input  logic [lpd_pkg::BYTE_W-1:0] i_byte,
    output logic                       o_res_valid,
    output lpd_pkg::t_result           o_res,
    output lpd_pkg::t_status           o_status
);

    logic [lpd_pkg::WORD_W-1:0] r_max_payload;
    logic [lpd_pkg::CNT_W-1:0]  r_hdr_cnt, n_hdr_cnt;
    logic [lpd_pkg::WORD_W-1:0] r_total, n_total;
    logic [lpd_pkg::WORD_W-1:0] r_length, n_length;
    logic [lpd_pkg::WORD_W-1:0] r_remaining, n_remaining;
    logic                       r_halted, n_halted;
    logic [lpd_pkg::WORD_W-1:0] w_shift_total;
    logic [lpd_pkg::WORD_W-1:0] w_shift_length;
    logic [lpd_pkg::WORD_W:0]   w_len_plus;

    // header words shifted in big-endian
    assign w_shift_total  = {r_total[lpd_pkg::WORD_W-lpd_pkg::BYTE_W-1:0], i_byte};
    assign w_shift_length = {r_length[lpd_pkg::WORD_W-lpd_pkg::BYTE_W-1:0], i_byte};
    // length plus header extra at full width, no wrap
    assign w_len_plus = {1'b0, w_shift_length}
                      + (lpd_pkg::WORD_W+1)'(lpd_pkg::TOTAL_EXTRA);

    // next state and result
    always_comb begin
        n_hdr_cnt   = r_hdr_cnt;
        n_total     = r_total;
        n_length    = r_length;
        n_remaining = r_remaining;
        n_halted    = r_halted;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_step && !r_halted) begin
            if (r_remaining != '0) begin
                // payload phase
                n_remaining         = r_remaining - 1'b1;
                o_res_valid         = 1'b1;
                o_res.kind          = lpd_pkg::KIND_PAYLOAD;
                o_res.payload_byte  = i_byte;
                o_res.last_in_frame = (r_remaining == lpd_pkg::WORD_W'(1));
            end else begin
                // header phase
                if (r_hdr_cnt < lpd_pkg::CNT_W'(lpd_pkg::HALF_BYTES)) begin
                    n_total = w_shift_total;
                end else begin
                    n_length = w_shift_length;
                end
                if (r_hdr_cnt == lpd_pkg::CNT_W'(lpd_pkg::HEADER_BYTES - 1)) begin
                    n_hdr_cnt   = '0;
                    o_res_valid = 1'b1;
                    if (w_shift_length > r_max_payload) begin
                        n_halted         = 1'b1;
                        o_res.kind       = lpd_pkg::KIND_ERROR;
                        o_res.error_code = lpd_pkg::ERR_OVER_LIMIT;
                    end else if (w_len_plus != {1'b0, r_total}) begin
                        n_halted         = 1'b1;
                        o_res.kind       = lpd_pkg::KIND_ERROR;
                        o_res.error_code = lpd_pkg::ERR_MISMATCH;
                    end else if (w_shift_length == '0) begin
                        o_res.kind          = lpd_pkg::KIND_EMPTY;
                        o_res.last_in_frame = 1'b1;
                    end else begin
                        o_res_valid = 1'b0;
                        n_remaining = w_shift_length;
                    end
                end else begin
                    n_hdr_cnt = r_hdr_cnt + 1'b1;
                end
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= '0;
            r_hdr_cnt     <= '0;
            r_remaining   <= '0;
            r_halted      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_payload <= i_cfg_data;
            end
            r_hdr_cnt   <= n_hdr_cnt;
            r_remaining <= n_remaining;
            r_halted    <= n_halted;
        end
    end

    // header words
    always_ff @(posedge i_clk) begin
        r_total  <= n_total;
        r_length <= n_length;
    end

    assign o_status.halted     = r_halted;
    assign o_status.in_payload = (r_remaining != '0);

endmodule

@@ rtl/lpd_out_reg.sv @@
// result register facing the output channel
module lpd_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  lpd_pkg::t_result i_res,
    output logic             o_free,
    lpd_result_if.source     o_out
);

    logic             r_valid;
    lpd_pkg::t_result r_res;

    // room for a new result when empty or being drained
    assign o_free = !r_valid || o_out.ready;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    // result capture
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.kind          = r_res.kind;
    assign o_out.payload_byte  = r_res.payload_byte;
    assign o_out.last_in_frame = r_res.last_in_frame;
    assign o_out.error_code    = r_res.error_code;

endmodule

@@ sim/testbench.sv @@
// self-checking testbench for the length-prefixed deframer
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lpd_pkg::*;

    localparam int          CLK_HALF_NS   = 5;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          RANDOM_BYTES  = 1900;
    localparam int          REPORT_LIMIT  = 10;
    localparam longint      TIMEOUT_NS    = 5_000_000;
    localparam logic [31:0] LIMIT_ALL     = 32'hFFFF_FFFF;

    // predicts deframer results and checks the words that come out
    class deframe_scoreboard;
        logic [WORD_W-1:0] max_len;
        int                hdr_count;
        logic [WORD_W-1:0] total_word;
        logic [WORD_W-1:0] length_word;
        logic [WORD_W-1:0] remaining;
        bit                halted;
        t_result           pending[$];
        int                fault_count;
        int                payload_seen;
        int                empty_seen;
        int                error_seen;

        function new();
            max_len      = '0;
            hdr_count    = 0;
            total_word   = '0;
            length_word  = '0;
            remaining    = '0;
            halted       = 1'b0;
            fault_count  = 0;
            payload_seen = 0;
            empty_seen   = 0;
            error_seen   = 0;
        endfunction

        function void set_limit(logic [WORD_W-1:0] value);
            max_len = value;
        endfunction

        function void push_result(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] data,
                                  logic last, logic code);
            t_result r;
            r.kind          = kind;
            r.payload_byte  = data;
            r.last_in_frame = last;
            r.error_code    = code;
            pending.push_back(r);
        endfunction

        // one accepted stream byte through the parser
        function void note_byte(logic [BYTE_W-1:0] b);
            if (halted) begin
                return;
            end
            // payload phase passes the byte on
            if (remaining != 0) begin
                remaining = remaining - 1;
                push_result(KIND_PAYLOAD, b, remaining == 0, 1'b0);
                return;
            end
            // header gathering, total first then length
            if (hdr_count < HALF_BYTES) begin
                total_word = {total_word[WORD_W-BYTE_W-1:0], b};
            end else begin
                length_word = {length_word[WORD_W-BYTE_W-1:0], b};
            end
            hdr_count++;
            if (hdr_count < HEADER_BYTES) begin
                return;
            end
            hdr_count = 0;
            // limit check ahead of the total check, sum kept at 33 bits
            if (length_word > max_len) begin
                halted = 1'b1;
                push_result(KIND_ERROR, '0, 1'b0, ERR_OVER_LIMIT);
            end else if ({1'b0, length_word} + 33'(TOTAL_EXTRA) != {1'b0, total_word}) begin
                halted = 1'b1;
                push_result(KIND_ERROR, '0, 1'b0, ERR_MISMATCH);
            end else if (length_word == 0) begin
                push_result(KIND_EMPTY, '0, 1'b1, 1'b0);
            end else begin
                remaining = length_word;
            end
        endfunction

        function void report_fault(string what);
            fault_count++;
            if (fault_count <= REPORT_LIMIT) begin
                $display("%t mismatch: %s", $realtime, what);
            end
        endfunction

        // compare an accepted result word with the oldest prediction
        function void check_result(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                report_fault($sformatf("unexpected word kind=%0d byte=%02h last=%0d err=%0d",
                             got.kind, got.payload_byte, got.last_in_frame,
                             got.error_code));
                return;
            end
            want = pending.pop_front();
            if (got.kind !== want.kind || got.payload_byte !== want.payload_byte ||
                got.last_in_frame !== want.last_in_frame ||
                got.error_code !== want.error_code) begin
                report_fault($sformatf({"expected kind=%0d byte=%02h last=%0d err=%0d, ",
                             "got kind=%0d byte=%02h last=%0d err=%0d"},
                             want.kind, want.payload_byte, want.last_in_frame,
                             want.error_code, got.kind, got.payload_byte,
                             got.last_in_frame, got.error_code));
            end
            case (want.kind)
                KIND_PAYLOAD: payload_seen++;
                KIND_EMPTY:   empty_seen++;
                default:      error_seen++;
            endcase
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [WORD_W-1:0] i_cfg_data;

    lpd_byte_if   in_if();
    lpd_result_if out_if();

    length_prefixed_deframer u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    deframe_scoreboard scoreboard = new();

    int  bytes_sent;
    int  frames_sent;
    int  limits_written;
    bit  src_steady;
    bit  sink_steady;
    bit  hold_request;
    string error_case;

    // clock
    always begin
        i_clk = 1'b1;
        #CLK_HALF_NS;
        i_clk = 1'b0;
        #CLK_HALF_NS;
    end

    // overall time limit
    initial begin
        #(TIMEOUT_NS);
        $display("%t timeout, %0d bytes sent, %0d words outstanding", $realtime,
                 bytes_sent, scoreboard.pending.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    // offer one byte, idling first for a random number of cycles unless the source is steady
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        if (bytes_sent % 48 == 0) begin
            src_steady = ($urandom_range(0, 3) == 0);
        end
        gap = src_steady ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.in_byte <= b;
        do @(posedge i_clk); while (!in_if.ready);
        scoreboard.note_byte(b);
        bytes_sent++;
    endtask

    // big-endian 32-bit header word
    task automatic send_word32(input logic [WORD_W-1:0] w);
        for (int i = HALF_BYTES - 1; i >= 0; i--) begin
            send_byte(w[i*BYTE_W +: BYTE_W]);
        end
    endtask

    // well-formed frame with random payload
    task automatic send_frame(input logic [WORD_W-1:0] len);
        send_word32(len + TOTAL_EXTRA);
        send_word32(len);
        for (int i = 0; i < int'(len); i++) begin
            send_byte(8'($urandom));
        end
        frames_sent++;
    endtask

    // stop offering and let every predicted word come out
    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (scoreboard.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [WORD_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        scoreboard.set_limit(value);
        limits_written++;
    endtask

    // result side, random stalls and one long hold-off
    initial begin
        t_result got;
        int      stall;
        int      taken;
        out_if.ready = 1'b0;
        taken        = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (taken % 40 == 0) begin
                sink_steady = ($urandom_range(0, 3) == 0);
            end
            if (hold_request) begin
                hold_request = 1'b0;
                stall        = HOLD_CYCLES;
            end else begin
                stall = sink_steady ? 0 : $urandom_range(0, 7);
            end
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!out_if.valid);
            got.kind          = out_if.kind;
            got.payload_byte  = out_if.payload_byte;
            got.last_in_frame = out_if.last_in_frame;
            got.error_code    = out_if.error_code;
            scoreboard.check_result(got);
            taken++;
        end
    end

    // stimulus and final verdict
    initial begin
        logic [WORD_W-1:0] limit;
        logic [WORD_W-1:0] len;
        logic [WORD_W-1:0] total;
        int                cap;
        int                phase_end;
        int                random_end;

        in_if.valid    = 1'b0;
        in_if.in_byte  = '0;
        i_cfg_we       = 1'b0;
        i_cfg_data     = '0;
        i_rst_n        = 1'b0;
        bytes_sent     = 0;
        frames_sent    = 0;
        limits_written = 0;
        src_steady     = 1'b0;
        sink_steady    = 1'b0;
        hold_request   = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty frame under the reset limit of zero
        send_frame(0);
        wait_drained();

        // limit raised to the top, then cut to zero in the middle of a payload
        write_limit(LIMIT_ALL);
        send_word32(3 + TOTAL_EXTRA);
        send_word32(3);
        send_byte(8'hA5);
        wait_drained();
        write_limit('0);
        send_byte(8'h00);
        send_byte(8'hFF);
        frames_sent++;
        send_frame(0);
        wait_drained();

        // random phases of well-formed frames under changing limits
        hold_request = 1'b1;
        random_end   = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < random_end) begin
            case ($urandom_range(0, 4))
                0:       limit = '0;
                1:       limit = LIMIT_ALL;
                2:       limit = $urandom_range(1, 8);
                default: limit = $urandom_range(9, 48);
            endcase
            write_limit(limit);
            cap       = (limit > 48) ? (($urandom_range(0, 3) == 0) ? 120 : 48) : int'(limit);
            phase_end = bytes_sent + $urandom_range(120, 320);
            while (bytes_sent < phase_end && bytes_sent < random_end) begin
                case ($urandom_range(0, 7))
                    0:       len = cap;
                    1:       len = 0;
                    2:       len = $urandom_range(0, cap);
                    default: len = $urandom_range(0, (cap > 12) ? 12 : cap);
                endcase
                send_frame(len);
            end
            wait_drained();
        end

        // one bad header at the end, since an error halts until reset
        case ($urandom_range(0, 2))
            0: begin
                error_case = "length over limit";
                limit      = $urandom_range(0, 40);
                write_limit(limit);
                len   = ($urandom_range(0, 3) == 0) ? LIMIT_ALL
                                                    : limit + $urandom_range(1, 1000);
                total = $urandom_range(0, 1) ? len + TOTAL_EXTRA : 32'($urandom);
            end
            1: begin
                error_case = "total mismatch";
                write_limit(LIMIT_ALL);
                len   = $urandom_range(0, 40);
                total = (len + TOTAL_EXTRA) ^ (32'd1 << $urandom_range(0, 31));
            end
            default: begin
                error_case = "total mismatch at the top of the length range";
                write_limit(LIMIT_ALL);
                len   = 32'hFFFF_FFFC + $urandom_range(0, 3);
                total = len + TOTAL_EXTRA;
            end
        endcase
        send_word32(total);
        send_word32(len);
        frames_sent++;
        // bytes after the error are dropped
        repeat (32) send_byte(8'($urandom));
        wait_drained();
        repeat (20) @(posedge i_clk);

        if (scoreboard.pending.size() != 0) begin
            scoreboard.report_fault($sformatf("%0d predicted words never arrived",
                                    scoreboard.pending.size()));
        end
        $display("%0d bytes in %0d frames, %0d limit writes, one long output hold-off",
                 bytes_sent, frames_sent, limits_written);
        $display("checked %0d payload, %0d empty-frame, %0d error words; final case: %s",
                 scoreboard.payload_seen, scoreboard.empty_seen, scoreboard.error_seen,
                 error_case);
        if (scoreboard.fault_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches in total", scoreboard.fault_count);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
